>>> rtl/core/sobq_pkg.sv
// Shared types and codes for the sonar obstacle qualifier and scan block.
// No dependencies.
package sobq_pkg;

  localparam int CONFIRM_RUN_DEF = 3;
  localparam int RANGE_BITS_DEF  = 16;

  localparam int RANGE_W = 16;
  localparam int SUM_W   = 24;
  localparam int ANGLE_W = 8;
  localparam int STEP_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SCAN   = 2'd1,
    CMD_PING   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DANGER  = 3'd1,
    EV_DETECT  = 3'd2,
    EV_CLEAR   = 3'd3,
    EV_SCAN    = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ZONE_CLEAR  = 2'd0,
    ZONE_DANGER = 2'd1,
    ZONE_DETECT = 2'd2
  } zone_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DANGER_LIMIT = 3'd0,
    REG_DETECT_LIMIT = 3'd1,
    REG_START_ANGLE  = 3'd2,
    REG_SWEEP_STEP   = 3'd3,
    REG_STOP_ANGLE   = 3'd4
  } reg_idx_t;

  localparam logic [ANGLE_W-1:0] ANGLE_POS90 = 8'd90;
  localparam logic [ANGLE_W-1:0] ANGLE_NEG90 = 8'hA6;

  typedef struct packed {
    logic [RANGE_W-1:0] danger_limit;
    logic [RANGE_W-1:0] detect_limit;
    logic [ANGLE_W-1:0] sweep_start_angle;
    logic [STEP_W-1:0]  sweep_step;
    logic [STEP_W-1:0]  sweep_stop_angle;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         event_code;
    logic [RANGE_W-1:0] event_range;
    logic [SUM_W-1:0]   left_sum;
    logic [SUM_W-1:0]   right_sum;
    logic [RANGE_W-1:0] left_best_range;
    logic [ANGLE_W-1:0] left_best_angle;
    logic [RANGE_W-1:0] right_best_range;
    logic [ANGLE_W-1:0] right_best_angle;
    logic [ANGLE_W-1:0] aim_angle;
  } result_t;

endpackage

>>> rtl/core/sobq_cfg.sv
// Configuration register file: zone limits and sweep geometry.
// Depends on sobq_pkg.
module sobq_cfg
  import sobq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.danger_limit      <= 16'd30;
      cfg.detect_limit      <= 16'd60;
      cfg.sweep_start_angle <= ANGLE_NEG90;
      cfg.sweep_step        <= 7'd15;
      cfg.sweep_stop_angle  <= 7'd90;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DANGER_LIMIT: cfg.danger_limit      <= wr_data;
        REG_DETECT_LIMIT: cfg.detect_limit      <= wr_data;
        REG_START_ANGLE:  cfg.sweep_start_angle <= wr_data[ANGLE_W-1:0];
        REG_SWEEP_STEP:   cfg.sweep_step        <= wr_data[STEP_W-1:0];
        REG_STOP_ANGLE:   cfg.sweep_stop_angle  <= wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/sobq_step.sv
// Per-item state update: zone qualification in ping-ahead mode and
// sweep accumulation in scan mode. Depends on sobq_pkg.
module sobq_step
  import sobq_pkg::*;
#(
  parameter int CONFIRM_RUN = CONFIRM_RUN_DEF,
  parameter int RANGE_BITS  = RANGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [1:0]         cmd,
  input  logic               sample_ok,
  input  logic [RANGE_W-1:0] range_value,
  input  cfg_t               cfg,
  output result_t            res
);

  localparam logic [RANGE_W-1:0] RANGE_MASK = RANGE_W'((32'd1 << RANGE_BITS) - 32'd1);

  logic                      scan_on, scan_on_next;
  zone_t                     zone, zone_next;
  logic [1:0]                clear_run, clear_run_next;
  logic [1:0]                detect_run, detect_run_next;
  logic signed [ANGLE_W-1:0] sweep_angle, sweep_angle_next;
  logic [SUM_W-1:0]          left_total, left_total_next;
  logic [SUM_W-1:0]          right_total, right_total_next;
  logic [RANGE_W-1:0]        left_peak, left_peak_next;
  logic signed [ANGLE_W-1:0] left_peak_angle, left_peak_angle_next;
  logic [RANGE_W-1:0]        right_peak, right_peak_next;
  logic signed [ANGLE_W-1:0] right_peak_angle, right_peak_angle_next;

  logic [RANGE_W-1:0]        rng;
  logic [1:0]                clear_bump, detect_bump;
  logic [SUM_W:0]            left_add, right_add;
  logic signed [ANGLE_W:0]   angle_sum;
  logic [ANGLE_W:0]          angle_mag;
  logic                      done;
  logic [2:0]                ev;
  logic [RANGE_W-1:0]        ev_range;

  assign rng         = range_value & RANGE_MASK;
  assign clear_bump  = (clear_run == 2'd3) ? 2'd3 : clear_run + 2'd1;
  assign detect_bump = (detect_run == 2'd3) ? 2'd3 : detect_run + 2'd1;
  assign left_add    = {1'b0, left_total} + (SUM_W+1)'(rng);
  assign right_add   = {1'b0, right_total} + (SUM_W+1)'(rng);
  assign angle_sum   = {sweep_angle[ANGLE_W-1], sweep_angle}
                     + $signed({2'b00, cfg.sweep_step});
  assign angle_mag   = angle_sum[ANGLE_W] ? (ANGLE_W+1)'(0) - angle_sum : angle_sum;

  always_comb begin
    scan_on_next          = scan_on;
    zone_next             = zone;
    clear_run_next        = clear_run;
    detect_run_next       = detect_run;
    sweep_angle_next      = sweep_angle;
    left_total_next       = left_total;
    right_total_next      = right_total;
    left_peak_next        = left_peak;
    left_peak_angle_next  = left_peak_angle;
    right_peak_next       = right_peak;
    right_peak_angle_next = right_peak_angle;
    done                  = 1'b0;
    ev                    = EV_NONE;
    ev_range              = '0;

    case (cmd)
      CMD_SCAN: begin
        scan_on_next          = 1'b1;
        left_total_next       = '0;
        right_total_next      = '0;
        left_peak_next        = '0;
        left_peak_angle_next  = ANGLE_POS90;
        right_peak_next       = '0;
        right_peak_angle_next = ANGLE_NEG90;
        sweep_angle_next      = cfg.sweep_start_angle;
      end
      CMD_PING: begin
        scan_on_next    = 1'b0;
        zone_next       = ZONE_CLEAR;
        clear_run_next  = '0;
        detect_run_next = '0;
      end
      CMD_SAMPLE: begin
        if (sample_ok && !scan_on) begin
          if (rng <= cfg.danger_limit) begin
            clear_run_next  = '0;
            detect_run_next = '0;
            if (zone != ZONE_DANGER) begin
              zone_next = ZONE_DANGER;
              ev        = EV_DANGER;
              ev_range  = rng;
            end
          end else if (rng <= cfg.detect_limit) begin
            clear_run_next = '0;
            if (zone != ZONE_DETECT) begin
              detect_run_next = detect_bump;
              if (32'(detect_bump) >= CONFIRM_RUN) begin
                zone_next = ZONE_DETECT;
                ev        = EV_DETECT;
                ev_range  = rng;
              end
            end
          end else begin
            detect_run_next = '0;
            if (zone != ZONE_CLEAR) begin
              clear_run_next = clear_bump;
              if (32'(clear_bump) >= CONFIRM_RUN) begin
                zone_next = ZONE_CLEAR;
                ev        = EV_CLEAR;
                ev_range  = rng;
              end
            end
          end
        end else if (sample_ok) begin
          // Positive angles are the left side; exactly zero touches neither.
          if (sweep_angle > 0) begin
            left_total_next = left_add[SUM_W] ? SUM_MAX : left_add[SUM_W-1:0];
            if (rng > left_peak || (rng == left_peak && sweep_angle < left_peak_angle)) begin
              left_peak_next       = rng;
              left_peak_angle_next = sweep_angle;
            end
          end else if (sweep_angle < 0) begin
            right_total_next = right_add[SUM_W] ? SUM_MAX : right_add[SUM_W-1:0];
            if (rng > right_peak || (rng == right_peak && sweep_angle > right_peak_angle)) begin
              right_peak_next       = rng;
              right_peak_angle_next = sweep_angle;
            end
          end
          if (angle_mag > {2'b00, cfg.sweep_stop_angle}) begin
            done            = 1'b1;
            ev              = EV_SCAN;
            scan_on_next    = 1'b0;
            zone_next       = ZONE_CLEAR;
            clear_run_next  = '0;
            detect_run_next = '0;
          end else begin
            sweep_angle_next = angle_sum[ANGLE_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.event_code       = ev;
    res.event_range      = ev_range;
    res.left_sum         = done ? left_total_next : '0;
    res.right_sum        = done ? right_total_next : '0;
    res.left_best_range  = done ? left_peak_next : '0;
    res.left_best_angle  = done ? left_peak_angle_next : '0;
    res.right_best_range = done ? right_peak_next : '0;
    res.right_best_angle = done ? right_peak_angle_next : '0;
    res.aim_angle        = scan_on_next ? sweep_angle_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on          <= 1'b0;
      zone             <= ZONE_CLEAR;
      clear_run        <= '0;
      detect_run       <= '0;
      sweep_angle      <= '0;
      left_total       <= '0;
      right_total      <= '0;
      left_peak        <= '0;
      left_peak_angle  <= ANGLE_POS90;
      right_peak       <= '0;
      right_peak_angle <= ANGLE_NEG90;
    end else if (en) begin
      scan_on          <= scan_on_next;
      zone             <= zone_next;
      clear_run        <= clear_run_next;
      detect_run       <= detect_run_next;
      sweep_angle      <= sweep_angle_next;
      left_total       <= left_total_next;
      right_total      <= right_total_next;
      left_peak        <= left_peak_next;
      left_peak_angle  <= left_peak_angle_next;
      right_peak       <= right_peak_next;
      right_peak_angle <= right_peak_angle_next;
    end
  end

endmodule

>>> rtl/core/sonar_obstacle_qualifier_and_scan.sv
// Sonar obstacle qualifier and scan sweep, top level.
// Path: item transfer into the input register, then the combinational state update
// between the two registers writes the result register.
// Throughput: one item per cycle unless result_ready is low while a result is held.
// Reset (rst, synchronous): both stages empty, ping-ahead mode, clear zone,
// configuration back to its defaults. Depends on sobq_pkg, sobq_cfg, sobq_step.
module sonar_obstacle_qualifier_and_scan
  import sobq_pkg::*;
#(
  parameter int CONFIRM_RUN = CONFIRM_RUN_DEF,
  parameter int RANGE_BITS  = RANGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [1:0]                   cmd,
  input  logic                         sample_ok,
  input  logic [RANGE_W-1:0]           range_value,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [2:0]                   event_code,
  output logic [RANGE_W-1:0]           event_range,
  output logic [SUM_W-1:0]             left_sum,
  output logic [SUM_W-1:0]             right_sum,
  output logic [RANGE_W-1:0]           left_best_range,
  output logic signed [ANGLE_W-1:0]    left_best_angle,
  output logic [RANGE_W-1:0]           right_best_range,
  output logic signed [ANGLE_W-1:0]    right_best_angle,
  output logic signed [ANGLE_W-1:0]    aim_angle
);

  cfg_t               cfg;
  result_t            res_comb;
  result_t            res;
  logic               stage_valid;
  logic [1:0]         stage_cmd;
  logic               stage_ok;
  logic [RANGE_W-1:0] stage_range;
  logic               advance;

  assign cfg_ready  = 1'b1;
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  sobq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sobq_step #(
    .CONFIRM_RUN (CONFIRM_RUN),
    .RANGE_BITS  (RANGE_BITS)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .cmd         (stage_cmd),
    .sample_ok   (stage_ok),
    .range_value (stage_range),
    .cfg         (cfg),
    .res         (res_comb)
  );

  // Input register: load on transfer, empty when the item moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_cmd   <= cmd;
      stage_ok    <= sample_ok;
      stage_range <= range_value;
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign event_code       = res.event_code;
  assign event_range      = res.event_range;
  assign left_sum         = res.left_sum;
  assign right_sum        = res.right_sum;
  assign left_best_range  = res.left_best_range;
  assign left_best_angle  = $signed(res.left_best_angle);
  assign right_best_range = res.right_best_range;
  assign right_best_angle = $signed(res.right_best_angle);
  assign aim_angle        = $signed(res.aim_angle);

endmodule
